// ===== design/packbits_row_encoder_unit_defines.svh =====
// ----------------------------------------------------------------------------
// PackBits row encoder - assertion macros
// Shared property shorthands for the encoder checkers.
// ----------------------------------------------------------------------------
`ifndef PACKBITS_ROW_ENCODER_UNIT_DEFINES_SVH
`define PACKBITS_ROW_ENCODER_UNIT_DEFINES_SVH

// same-cycle implication
`define PBRE_ASSERT_IMP(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("pbre: property violated");

// next-cycle implication
`define PBRE_ASSERT_NXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("pbre: property violated");

`endif

// ===== design/pbre_pkg.sv =====
// ----------------------------------------------------------------------------
// PackBits row encoder - package
// Shared constants, register indexes and the packer request type.
// ----------------------------------------------------------------------------
`default_nettype none

package pbre_pkg;

    localparam int unsigned LIT_DEPTH           = 128;
    localparam int unsigned LIT_AW              = $clog2(LIT_DEPTH);
    localparam int unsigned LIT_CW              = LIT_AW + 1;
    localparam int unsigned MAX_RUN             = 128;
    localparam int unsigned OUT_WIDTH_BYTES_DEF = 8;
    localparam int unsigned MAX_RESULTS         = 18;
    localparam int unsigned RES_CW              = $clog2(MAX_RESULTS);
    localparam int unsigned MIN_DIM             = 4;
    localparam int unsigned DIM_W               = 15;
    localparam int unsigned TOTAL_W             = 16;
    localparam int unsigned OUT_W               = 64;
    localparam int unsigned CNT_W               = 4;
    localparam int unsigned CFG_IDX_W           = 2;
    localparam int unsigned CFG_DATA_W          = 15;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_COMPRESS,
        CFG_ROW_WIDTH,
        CFG_IMAGE_HEIGHT
    } t_cfg_idx;

    typedef struct packed {
        logic                put;
        logic                fin;
        logic [7:0]          data;
        logic                row_end;
        logic [TOTAL_W-1:0]  row_bytes;
    } t_pack_req;

endpackage

`default_nettype wire

// ===== design/pbre_out_packer.sv =====
// ----------------------------------------------------------------------------
// PackBits row encoder - output packer
// Gathers packed bytes into words and holds the output register.
// ----------------------------------------------------------------------------
`default_nettype none

module pbre_out_packer #(
    parameter int unsigned OUT_WIDTH_BYTES = pbre_pkg::OUT_WIDTH_BYTES_DEF
) (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire pbre_pkg::t_pack_req           i_req,
    output logic                               o_ack,
    output logic                               o_valid,
    input  wire logic                          i_stall,
    output logic [pbre_pkg::OUT_W-1:0]         o_out_bytes,
    output logic [pbre_pkg::CNT_W-1:0]         o_byte_count,
    output logic                               o_row_end,
    output logic [pbre_pkg::TOTAL_W-1:0]       o_row_bytes,
    output logic                               o_last
);
    import pbre_pkg::*;

    localparam int unsigned CW = $clog2(OUT_WIDTH_BYTES + 1);

    logic [OUT_WIDTH_BYTES-1:0][7:0] r_acc, n_acc;
    logic [CW-1:0]                   r_cnt, n_cnt;
    logic [RES_CW-1:0]               r_res, n_res;

    logic                r_o_valid;
    logic [OUT_W-1:0]    r_o_bytes;
    logic [CNT_W-1:0]    r_o_count;
    logic                r_o_row_end;
    logic [TOTAL_W-1:0]  r_o_row_bytes;
    logic                r_o_last;

    logic load_ok, acc_full, need_fin, ld, ld_last;

    always_comb begin
        load_ok  = !r_o_valid || !i_stall;
        acc_full = (r_cnt == CW'(OUT_WIDTH_BYTES));
        need_fin = (r_cnt != '0) || i_req.row_end;
        n_acc    = r_acc;
        n_cnt    = r_cnt;
        n_res    = r_res;
        o_ack    = 1'b0;
        ld       = 1'b0;
        ld_last  = 1'b0;
        if (i_req.put) begin
            if (!acc_full) begin
                o_ack = 1'b1;
                for (int i = 0; i < OUT_WIDTH_BYTES; i++) begin
                    if (CW'(i) == r_cnt) begin
                        n_acc[i] = i_req.data;
                    end
                end
                n_cnt = r_cnt + CW'(1);
            end else if (r_res == RES_CW'(MAX_RESULTS - 1)) begin
                o_ack = 1'b1;  // result limit reached, byte dropped
            end else if (load_ok) begin
                o_ack    = 1'b1;
                ld       = 1'b1;
                n_acc    = '0;
                n_acc[0] = i_req.data;
                n_cnt    = CW'(1);
                n_res    = r_res + RES_CW'(1);
            end
        end else if (i_req.fin) begin
            if (!need_fin) begin
                o_ack = 1'b1;
                n_res = '0;
            end else if (load_ok) begin
                o_ack   = 1'b1;
                ld      = 1'b1;
                ld_last = 1'b1;
                n_acc   = '0;
                n_cnt   = '0;
                n_res   = '0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_acc     <= '0;
            r_cnt     <= '0;
            r_res     <= '0;
            r_o_valid <= 1'b0;
        end else begin
            r_acc <= n_acc;
            r_cnt <= n_cnt;
            r_res <= n_res;
            if (ld) begin
                r_o_valid <= 1'b1;
            end else if (!i_stall) begin
                r_o_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (ld) begin
            r_o_bytes     <= OUT_W'(r_acc);
            r_o_count     <= CNT_W'(r_cnt);
            r_o_last      <= ld_last;
            r_o_row_end   <= ld_last && i_req.row_end;
            r_o_row_bytes <= (ld_last && i_req.row_end) ? i_req.row_bytes : '0;
        end
    end

    assign o_valid      = r_o_valid;
    assign o_out_bytes  = r_o_bytes;
    assign o_byte_count = r_o_count;
    assign o_row_end    = r_o_row_end;
    assign o_row_bytes  = r_o_row_bytes;
    assign o_last       = r_o_last;

endmodule

`default_nettype wire

// ===== design/packbits_row_encoder_unit.sv =====
// ----------------------------------------------------------------------------
// PackBits row encoder - top level
// PackBits-encodes plane rows one byte at a time; raw copy when compression is off or a dimension is below MIN_DIM.
//
//   channel  dir  handshake                   payload
//   in       in   i_in_valid / o_in_stall     i_data_byte
//   out      out  o_out_valid / i_out_stall   o_out_bytes, o_byte_count,
//                                             o_row_end, o_row_bytes, o_last
//   cfg      in   i_cfg_we                    i_cfg_index, i_cfg_data
//
// One byte at a time: a byte that closes nothing passes S_UPDATE and S_END; a run
// close, each packet byte, each literal push and each dispatch step take a state of their own.
// The literal store has one read port: a flush reads the stored bytes in order from address 0.
// Reset is synchronous; the literal store is not cleared (no clearing pass).
// An output stall holds the sequencer once the output register is full and a
// word must move into it: a byte that finds the accumulator full (below the result limit), or the end
// of a byte with packed bytes still in the accumulator or at a row end.
// ----------------------------------------------------------------------------
`default_nettype none

module packbits_row_encoder_unit #(
    parameter int unsigned OUT_WIDTH_BYTES = pbre_pkg::OUT_WIDTH_BYTES_DEF
) (
    input  wire logic                            i_clk,
    input  wire logic                            i_rst_n,
    input  wire logic                            i_in_valid,
    output logic                                 o_in_stall,
    input  wire logic [7:0]                      i_data_byte,
    output logic                                 o_out_valid,
    input  wire logic                            i_out_stall,
    output logic [pbre_pkg::OUT_W-1:0]           o_out_bytes,
    output logic [pbre_pkg::CNT_W-1:0]           o_byte_count,
    output logic                                 o_row_end,
    output logic [pbre_pkg::TOTAL_W-1:0]         o_row_bytes,
    output logic                                 o_last,
    input  wire logic                            i_cfg_we,
    input  wire logic [pbre_pkg::CFG_IDX_W-1:0]  i_cfg_index,
    input  wire logic [pbre_pkg::CFG_DATA_W-1:0] i_cfg_data
);
    import pbre_pkg::*;

    typedef enum logic [3:0] {
        S_IDLE, S_RAW, S_UPDATE, S_CLOSE, S_PUSH2, S_PUSH1,
        S_LHDR, S_LDAT, S_RHDR, S_RVAL, S_DISP, S_END
    } t_state;

    typedef enum logic [2:0] {
        PH_DIFF, PH_GRP, PH_GRP_F, PH_ROW, PH_ROW_F
    } t_phase;

    // configuration
    logic             r_compress;
    logic [DIM_W-1:0] r_row_width;
    logic [DIM_W-1:0] r_image_height;

    // sequencer state
    t_state              r_state, n_state;
    t_phase              r_phase, n_phase;
    logic [7:0]          r_byte, n_byte;
    logic [LIT_CW-1:0]   r_lit_cnt, n_lit_cnt;
    logic [7:0]          r_run_val, n_run_val;
    logic [7:0]          r_run_len, n_run_len;
    logic [7:0]          r_group, n_group;
    logic                r_in_lit, n_in_lit;
    logic [DIM_W-1:0]    r_column, n_column;
    logic [TOTAL_W-1:0]  r_total, n_total;
    logic [TOTAL_W-1:0]  r_final, n_final;
    logic                r_row_done, n_row_done;
    logic                r_rep_pend, n_rep_pend;
    logic [7:0]          r_rep_hdr, n_rep_hdr;
    logic [LIT_AW-1:0]   r_idx, n_idx;

    // literal store
    logic [7:0]          r_lit_mem [LIT_DEPTH];
    logic [7:0]          r_rd_data;
    logic                mem_we, mem_re;
    logic [LIT_AW-1:0]   mem_raddr;

    t_pack_req           req;
    logic                pk_ack;

    logic                raw_mode;
    logic [7:0]          grp_inc;
    logic [DIM_W-1:0]    col_inc;
    logic [7:0]          tot_add;
    logic [TOTAL_W:0]    tot_sum;
    logic [TOTAL_W-1:0]  tot_sat;
    logic                lit_room;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_compress     <= 1'b1;
            r_row_width    <= DIM_W'(MIN_DIM);
            r_image_height <= DIM_W'(MIN_DIM);
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                CFG_COMPRESS:     r_compress     <= i_cfg_data[0];
                CFG_ROW_WIDTH:    r_row_width    <= i_cfg_data;
                CFG_IMAGE_HEIGHT: r_image_height <= i_cfg_data;
                default: ;
            endcase
        end
    end

    assign raw_mode = !r_compress || (r_row_width < DIM_W'(MIN_DIM))
                      || (r_image_height < DIM_W'(MIN_DIM));
    assign grp_inc  = r_group + 8'd1;
    assign col_inc  = r_column + DIM_W'(1);
    assign lit_room = (r_lit_cnt < LIT_CW'(LIT_DEPTH));
    assign tot_add  = (r_state == S_LHDR) ? (8'(r_lit_cnt) + 8'd1) : 8'd2;
    assign tot_sum  = {1'b0, r_total} + (TOTAL_W + 1)'(tot_add);
    assign tot_sat  = tot_sum[TOTAL_W] ? '1 : tot_sum[TOTAL_W-1:0];
    assign o_in_stall = (r_state != S_IDLE);

    always_comb begin
        n_state    = r_state;
        n_phase    = r_phase;
        n_byte     = r_byte;
        n_lit_cnt  = r_lit_cnt;
        n_run_val  = r_run_val;
        n_run_len  = r_run_len;
        n_group    = r_group;
        n_in_lit   = r_in_lit;
        n_column   = r_column;
        n_total    = r_total;
        n_final    = r_final;
        n_row_done = r_row_done;
        n_rep_pend = r_rep_pend;
        n_rep_hdr  = r_rep_hdr;
        n_idx      = r_idx;
        mem_we     = 1'b0;
        mem_re     = 1'b0;
        mem_raddr  = r_idx;
        req        = '0;
        unique case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    n_byte = i_data_byte;
                    if (raw_mode) begin
                        n_state = S_RAW;
                    end else begin
                        n_phase = PH_DIFF;
                        n_state = (r_run_len != 8'd0 && i_data_byte != r_run_val)
                                  ? S_CLOSE : S_UPDATE;
                    end
                end
            end
            S_RAW: begin
                req.put  = 1'b1;
                req.data = r_byte;
                if (pk_ack) begin
                    n_state = S_END;
                end
            end
            S_UPDATE: begin
                n_run_val = r_byte;
                n_run_len = r_run_len + 8'd1;
                n_group   = grp_inc;
                n_column  = col_inc;
                if (grp_inc >= 8'(MAX_RUN)) begin
                    n_phase = PH_GRP;
                    n_state = S_CLOSE;
                end else if (col_inc >= r_row_width) begin
                    n_phase = PH_ROW;
                    n_state = S_CLOSE;
                end else begin
                    n_state = S_END;
                end
            end
            S_CLOSE: begin
                n_run_len  = 8'd0;
                n_rep_pend = 1'b0;
                n_rep_hdr  = 8'd1 - r_run_len;
                if (r_run_len == 8'd0) begin
                    n_state = S_DISP;
                end else if (r_run_len >= 8'd3 || (r_run_len == 8'd2 && !r_in_lit)) begin
                    n_rep_pend = 1'b1;
                    n_in_lit   = 1'b0;
                    n_state    = (r_lit_cnt != '0) ? S_LHDR : S_RHDR;
                end else if (r_run_len == 8'd2) begin
                    n_state = S_PUSH2;
                end else begin
                    n_in_lit = 1'b1;
                    n_state  = S_PUSH1;
                end
            end
            S_PUSH2, S_PUSH1: begin
                if (lit_room) begin
                    mem_we    = 1'b1;
                    n_lit_cnt = r_lit_cnt + LIT_CW'(1);
                end
                n_state = (r_state == S_PUSH2) ? S_PUSH1 : S_DISP;
            end
            S_LHDR: begin
                req.put  = 1'b1;
                req.data = 8'(r_lit_cnt) - 8'd1;
                if (pk_ack) begin
                    mem_re    = 1'b1;
                    mem_raddr = '0;
                    n_idx     = '0;
                    n_total   = tot_sat;
                    n_state   = S_LDAT;
                end
            end
            S_LDAT: begin
                req.put  = 1'b1;
                req.data = r_rd_data;
                if (pk_ack) begin
                    if ({1'b0, r_idx} == r_lit_cnt - LIT_CW'(1)) begin
                        n_lit_cnt = '0;
                        n_state   = r_rep_pend ? S_RHDR : S_DISP;
                    end else begin
                        mem_re    = 1'b1;
                        mem_raddr = r_idx + LIT_AW'(1);
                        n_idx     = r_idx + LIT_AW'(1);
                    end
                end
            end
            S_RHDR: begin
                req.put  = 1'b1;
                req.data = r_rep_hdr;
                if (pk_ack) begin
                    n_state = S_RVAL;
                end
            end
            S_RVAL: begin
                req.put  = 1'b1;
                req.data = r_run_val;
                if (pk_ack) begin
                    n_total    = tot_sat;
                    n_rep_pend = 1'b0;
                    n_state    = S_DISP;
                end
            end
            S_DISP: begin
                unique case (r_phase)
                    PH_DIFF: begin
                        n_state = S_UPDATE;
                    end
                    PH_GRP, PH_ROW: begin
                        n_phase    = (r_phase == PH_GRP) ? PH_GRP_F : PH_ROW_F;
                        n_rep_pend = 1'b0;
                        n_state    = (r_lit_cnt != '0) ? S_LHDR : S_DISP;
                    end
                    PH_GRP_F: begin
                        n_group  = 8'd0;
                        n_in_lit = 1'b0;
                        if (r_column >= r_row_width) begin
                            n_phase = PH_ROW;
                            n_state = S_CLOSE;
                        end else begin
                            n_state = S_END;
                        end
                    end
                    PH_ROW_F: begin
                        n_in_lit   = 1'b0;
                        n_group    = 8'd0;
                        n_column   = '0;
                        n_row_done = 1'b1;
                        n_final    = r_total;
                        n_total    = '0;
                        n_state    = S_END;
                    end
                    default: n_state = S_END;
                endcase
            end
            S_END: begin
                req.fin       = 1'b1;
                req.row_end   = r_row_done;
                req.row_bytes = r_final;
                if (pk_ack) begin
                    n_row_done = 1'b0;
                    n_state    = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= S_IDLE;
            r_phase    <= PH_DIFF;
            r_lit_cnt  <= '0;
            r_run_val  <= 8'd0;
            r_run_len  <= 8'd0;
            r_group    <= 8'd0;
            r_in_lit   <= 1'b0;
            r_column   <= '0;
            r_total    <= '0;
            r_row_done <= 1'b0;
            r_rep_pend <= 1'b0;
        end else begin
            r_state    <= n_state;
            r_phase    <= n_phase;
            r_lit_cnt  <= n_lit_cnt;
            r_run_val  <= n_run_val;
            r_run_len  <= n_run_len;
            r_group    <= n_group;
            r_in_lit   <= n_in_lit;
            r_column   <= n_column;
            r_total    <= n_total;
            r_row_done <= n_row_done;
            r_rep_pend <= n_rep_pend;
        end
        r_byte    <= n_byte;
        r_final   <= n_final;
        r_rep_hdr <= n_rep_hdr;
        r_idx     <= n_idx;
    end

    // pushes and flush reads never share a cycle
    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            r_lit_mem[r_lit_cnt[LIT_AW-1:0]] <= r_run_val;
        end
        if (mem_re) begin
            r_rd_data <= r_lit_mem[mem_raddr];
        end
    end

    pbre_out_packer #(
        .OUT_WIDTH_BYTES (OUT_WIDTH_BYTES)
    ) u_packer (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_req        (req),
        .o_ack        (pk_ack),
        .o_valid      (o_out_valid),
        .i_stall      (i_out_stall),
        .o_out_bytes  (o_out_bytes),
        .o_byte_count (o_byte_count),
        .o_row_end    (o_row_end),
        .o_row_bytes  (o_row_bytes),
        .o_last       (o_last)
    );

endmodule

`default_nettype wire

// ===== design/pbre_checker.sv =====
// ----------------------------------------------------------------------------
// PackBits row encoder - port checker
// Watches the top-level ports; bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

`include "packbits_row_encoder_unit_defines.svh"

module pbre_checker #(
    parameter int unsigned OUT_WIDTH_BYTES = pbre_pkg::OUT_WIDTH_BYTES_DEF
) (
    input wire logic                            i_clk,
    input wire logic                            i_rst_n,
    input wire logic                            i_in_valid,
    input wire logic                            o_in_stall,
    input wire logic                            o_out_valid,
    input wire logic                            i_out_stall,
    input wire logic [pbre_pkg::OUT_W-1:0]      o_out_bytes,
    input wire logic [pbre_pkg::CNT_W-1:0]      o_byte_count,
    input wire logic                            o_row_end,
    input wire logic [pbre_pkg::TOTAL_W-1:0]    o_row_bytes,
    input wire logic                            o_last
);
    import pbre_pkg::*;

    `PBRE_ASSERT_NXT(a_out_hold, i_clk, i_rst_n, o_out_valid && i_out_stall, o_out_valid && $stable(o_out_bytes) && $stable(o_byte_count) && $stable(o_last))
    `PBRE_ASSERT_IMP(a_mid_word_full, i_clk, i_rst_n, o_out_valid && !o_last, o_byte_count == CNT_W'(OUT_WIDTH_BYTES))
    `PBRE_ASSERT_IMP(a_row_end_last, i_clk, i_rst_n, o_out_valid && o_row_end, o_last)
    `PBRE_ASSERT_IMP(a_row_bytes_zero, i_clk, i_rst_n, o_out_valid && !o_row_end, o_row_bytes == '0)
    `PBRE_ASSERT_NXT(a_one_at_a_time, i_clk, i_rst_n, i_in_valid && !o_in_stall, o_in_stall)

endmodule

bind packbits_row_encoder_unit pbre_checker #(
    .OUT_WIDTH_BYTES (OUT_WIDTH_BYTES)
) u_pbre_checker (
    .i_clk        (i_clk),
    .i_rst_n      (i_rst_n),
    .i_in_valid   (i_in_valid),
    .o_in_stall   (o_in_stall),
    .o_out_valid  (o_out_valid),
    .i_out_stall  (i_out_stall),
    .o_out_bytes  (o_out_bytes),
    .o_byte_count (o_byte_count),
    .o_row_end    (o_row_end),
    .o_row_bytes  (o_row_bytes),
    .o_last       (o_last)
);

`default_nettype wire
